// File: hdl/gbe_pkg.sv
// Shared constants, command and status types of the grid boundary edge extractor.
// No dependencies; every other file of the block but gbe_item_if imports this package.
`default_nettype none

package gbe_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int DIM_W   = 7;
    localparam int PAD_W   = 7;
    localparam int XY_W    = 8;
    localparam int YY_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int AREA_W    = $clog2(MEM_DEPTH + 1);
    localparam int TROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int TCOL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    localparam logic [1:0] SIDE_UP    = 2'd0;
    localparam logic [1:0] SIDE_DOWN  = 2'd1;
    localparam logic [1:0] SIDE_LEFT  = 2'd2;
    localparam logic [1:0] SIDE_RIGHT = 2'd3;

    typedef struct packed {
        logic op;
        logic solid;
    } cmd_t;

    typedef struct packed {
        logic finished;
        logic busy;
    } bk_stat_t;

endpackage

`default_nettype wire

// File: hdl/gbe_item_if.sv
// Input item channel: valid/ready handshake with the kind and solid fields.
// Depends on nothing.
`default_nettype none

interface gbe_item_if;
    logic valid;
    logic ready;
    logic kind;
    logic solid;

    modport source (output valid, output kind, output solid, input ready);
    modport sink (input valid, input kind, input solid, output ready);
endinterface

`default_nettype wire

// File: hdl/gbe_res_if.sv
// Result channel: valid/ready handshake with the edge or done payload.
// Depends on gbe_pkg for field widths.
`default_nettype none

interface gbe_res_if;
    import gbe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    has_edge;
    logic                    done_res;
    logic [PAD_W-1:0]        cell_row;
    logic [PAD_W-1:0]        cell_col;
    logic [1:0]              side;
    logic signed [XY_W-1:0]  start_x;
    logic signed [YY_W-1:0]  start_y;
    logic signed [XY_W-1:0]  end_x;
    logic signed [YY_W-1:0]  end_y;

    modport source (output valid, output has_edge, output done_res, output cell_row,
                    output cell_col, output side, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink (input valid, input has_edge, input done_res, input cell_row,
                  input cell_col, input side, input start_x, input start_y,
                  input end_x, input end_y, output ready);
endinterface

`default_nettype wire

// File: hdl/gbe_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on gbe_pkg for field widths.
`default_nettype none

interface gbe_cfg_if;
    import gbe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/gbe_front.sv
// Front stage: accepts input transactions and classifies them into load or step commands.
// Depends on gbe_pkg and gbe_item_if.
`default_nettype none

module gbe_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    gbe_item_if.sink           item,
    output gbe_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);
    import gbe_pkg::*;

    logic hv_reg;
    logic hv_next;
    cmd_t hcmd_reg;
    cmd_t hcmd_next;
    logic take;

    assign item.ready = !hv_reg || cmd_ready;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        hv_next   = hv_reg;
        hcmd_next = hcmd_reg;
        if (hv_reg && cmd_ready)
        begin
            hv_next = 1'b0;
        end
        if (take)
        begin
            hv_next         = 1'b1;
            hcmd_next.op    = item.kind ? OP_STEP : OP_LOAD;
            hcmd_next.solid = item.kind ? 1'b0 : item.solid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
        end
        else
        begin
            hv_reg <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hcmd_reg <= hcmd_next;
    end

    assign cmd       = hcmd_reg;
    assign cmd_valid = hv_reg;

endmodule

`default_nettype wire

// File: hdl/gbe_fifo.sv
// Short command queue between the front stage and the scan engine.
// Depends on gbe_pkg.
`default_nettype none

module gbe_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gbe_pkg::cmd_t in_cmd,
    input  wire logic          in_valid,
    output logic               in_ready,
    output gbe_pkg::cmd_t      out_cmd,
    output logic               out_valid,
    input  wire logic          out_ready
);
    import gbe_pkg::*;

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wp_reg;
    logic [QP_W-1:0] wp_next;
    logic [QP_W-1:0] rp_reg;
    logic [QP_W-1:0] rp_next;
    logic [QC_W-1:0] cnt_reg;
    logic [QC_W-1:0] cnt_next;
    logic            push;
    logic            pop;

    assign in_ready  = (cnt_reg != QC_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = slot_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + QP_W'(1);
        end
        if (pop)
        begin
            rp_next = (rp_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + QP_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QC_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/gbe_back.sv
// Scan engine: tile mask memory, load pointer, configuration registers and edge search.
// Depends on gbe_pkg, gbe_cfg_if and gbe_res_if.
`default_nettype none

module gbe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gbe_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    gbe_cfg_if.sink            cfg,
    gbe_res_if.source          result,
    output gbe_pkg::bk_stat_t  stat
);
    import gbe_pkg::*;

    localparam int WIN_N = 13;
    localparam int WIN_W = $clog2(WIN_N);
    localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(WIN_N - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    function automatic logic signed [2:0] win_dr(input logic [WIN_W-1:0] k);
        logic signed [2:0] v;
        case (k)
            4'd0:    v = -3'sd2;
            4'd1:    v = -3'sd1;
            4'd2:    v = -3'sd1;
            4'd3:    v = -3'sd1;
            4'd9:    v = 3'sd1;
            4'd10:   v = 3'sd1;
            4'd11:   v = 3'sd1;
            4'd12:   v = 3'sd2;
            default: v = 3'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [2:0] win_dc(input logic [WIN_W-1:0] k);
        logic signed [2:0] v;
        case (k)
            4'd1:    v = -3'sd1;
            4'd3:    v = 3'sd1;
            4'd4:    v = -3'sd2;
            4'd5:    v = -3'sd1;
            4'd7:    v = 3'sd1;
            4'd8:    v = 3'sd2;
            4'd9:    v = -3'sd1;
            4'd11:   v = 3'sd1;
            default: v = 3'sd0;
        endcase
        return v;
    endfunction

    function automatic logic frame_of(input logic [PAD_W-1:0] pr, input logic [PAD_W-1:0] pc,
                                      input logic [PAD_W-1:0] rp1,
                                      input logic [PAD_W-1:0] cp1);
        return (pr == '0) || (pc == '0) || (pr == rp1) || (pc == cp1);
    endfunction

    function automatic logic border_of(input logic fr, input logic self_s, input logic a,
                                       input logic b, input logic c, input logic d);
        return fr || (!self_s && (a || b || c || d));
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic mem [MEM_DEPTH];

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [WIN_W-1:0]  k_reg;
    logic [WIN_W-1:0]  k_next;
    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  rows_next;
    logic [DIM_W-1:0]  cols_reg;
    logic [DIM_W-1:0]  cols_next;
    logic [AREA_W-1:0] lp_reg;
    logic [AREA_W-1:0] lp_next;
    logic [PAD_W-1:0]  srow_reg;
    logic [PAD_W-1:0]  srow_next;
    logic [PAD_W-1:0]  scol_reg;
    logic [PAD_W-1:0]  scol_next;
    logic [1:0]        sside_reg;
    logic [1:0]        sside_next;
    logic              fin_reg;
    logic              fin_next;
    logic              cap_reg;
    logic              rdv_reg;
    logic              rd_reg;
    logic [WIN_W-1:0]  rk_reg;
    logic [WIN_N-1:0]  win_reg;
    logic              ov_reg;
    logic              ov_next;

    logic              out_has_edge_reg;
    logic              out_done_reg;
    logic [PAD_W-1:0]  out_row_reg;
    logic [PAD_W-1:0]  out_col_reg;
    logic [1:0]        out_side_reg;
    logic signed [XY_W-1:0] out_sx_reg;
    logic signed [YY_W-1:0] out_sy_reg;
    logic signed [XY_W-1:0] out_ex_reg;
    logic signed [YY_W-1:0] out_ey_reg;

    logic [AREA_W-1:0] area;
    logic [PAD_W-1:0]  rp1;
    logic [PAD_W-1:0]  cp1;
    logic              out_free;
    logic              done_now;
    logic              mem_we;
    logic              emit_edge;
    logic              emit_done;
    logic              cfg_wr;

    logic signed [PAD_W+1:0] tr_s;
    logic signed [PAD_W+1:0] tc_s;
    logic              in_map;
    logic [AREA_W-1:0] lin;
    logic [ADDR_W-1:0] rd_addr;

    logic              bc;
    logic              bu;
    logic              bd;
    logic              bl;
    logic              br;
    logic [3:0]        edges;
    logic [3:0]        cand;
    logic              any_edge;
    logic [1:0]        pick;
    logic [PAD_W-1:0]  adv_col;
    logic [PAD_W-1:0]  adv_row;
    logic              adv_wrap;

    logic signed [PAD_W+1:0] dd;
    logic signed [PAD_W+1:0] ss;
    logic signed [PAD_W+1:0] sx_w;
    logic signed [PAD_W+1:0] sy_w;
    logic signed [PAD_W+1:0] ex_w;
    logic signed [PAD_W+1:0] ey_w;

    assign area     = AREA_W'(rows_reg) * AREA_W'(cols_reg);
    assign rp1      = PAD_W'(rows_reg) + PAD_W'(1);
    assign cp1      = PAD_W'(cols_reg) + PAD_W'(1);
    assign out_free = !ov_reg || result.ready;
    assign done_now = fin_reg || (srow_reg > rp1) || (scol_reg > cp1);
    assign cfg_wr   = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    assign tr_s = $signed({2'b00, srow_reg}) + (PAD_W+2)'(win_dr(k_reg)) - (PAD_W+2)'(1);
    assign tc_s = $signed({2'b00, scol_reg}) + (PAD_W+2)'(win_dc(k_reg)) - (PAD_W+2)'(1);
    assign in_map = !tr_s[PAD_W+1] && !tc_s[PAD_W+1]
                    && (tr_s[PAD_W:0] < (PAD_W+1)'(rows_reg))
                    && (tc_s[PAD_W:0] < (PAD_W+1)'(cols_reg));
    assign lin = AREA_W'(tr_s[TROW_W-1:0]) * AREA_W'(cols_reg) + AREA_W'(tc_s[TCOL_W-1:0]);
    assign rd_addr = lin[ADDR_W-1:0];

    assign bc = border_of(frame_of(srow_reg, scol_reg, rp1, cp1), win_reg[6],
                          win_reg[2], win_reg[10], win_reg[5], win_reg[7]);
    assign bu = border_of(frame_of(srow_reg - PAD_W'(1), scol_reg, rp1, cp1), win_reg[2],
                          win_reg[0], win_reg[6], win_reg[1], win_reg[3]);
    assign bd = border_of(frame_of(srow_reg + PAD_W'(1), scol_reg, rp1, cp1), win_reg[10],
                          win_reg[6], win_reg[12], win_reg[9], win_reg[11]);
    assign bl = border_of(frame_of(srow_reg, scol_reg - PAD_W'(1), rp1, cp1), win_reg[5],
                          win_reg[1], win_reg[9], win_reg[4], win_reg[6]);
    assign br = border_of(frame_of(srow_reg, scol_reg + PAD_W'(1), rp1, cp1), win_reg[7],
                          win_reg[3], win_reg[11], win_reg[6], win_reg[8]);

    assign edges[SIDE_UP]    = bc && (srow_reg != '0) && !bu;
    assign edges[SIDE_DOWN]  = bc && (srow_reg != rp1) && !bd;
    assign edges[SIDE_LEFT]  = bc && (scol_reg != '0) && !bl;
    assign edges[SIDE_RIGHT] = bc && (scol_reg != cp1) && !br;
    assign cand     = edges & (4'b1111 << sside_reg);
    assign any_edge = |cand;

    always_comb
    begin
        if (cand[SIDE_UP])
        begin
            pick = SIDE_UP;
        end
        else if (cand[SIDE_DOWN])
        begin
            pick = SIDE_DOWN;
        end
        else if (cand[SIDE_LEFT])
        begin
            pick = SIDE_LEFT;
        end
        else
        begin
            pick = SIDE_RIGHT;
        end
    end

    assign adv_wrap = (scol_reg + PAD_W'(1)) > cp1;
    assign adv_col  = adv_wrap ? '0 : scol_reg + PAD_W'(1);
    assign adv_row  = adv_wrap ? srow_reg + PAD_W'(1) : srow_reg;

    assign dd = $signed({2'b00, srow_reg}) - $signed({2'b00, scol_reg});
    assign ss = $signed({2'b00, srow_reg}) + $signed({2'b00, scol_reg});

    always_comb
    begin
        case (pick)
            SIDE_UP:
            begin
                sx_w = dd;
                sy_w = ss - (PAD_W+2)'(2);
                ex_w = dd - (PAD_W+2)'(1);
                ey_w = ss - (PAD_W+2)'(1);
            end
            SIDE_DOWN:
            begin
                sx_w = dd + (PAD_W+2)'(1);
                sy_w = ss - (PAD_W+2)'(1);
                ex_w = dd;
                ey_w = ss;
            end
            SIDE_LEFT:
            begin
                sx_w = dd;
                sy_w = ss - (PAD_W+2)'(2);
                ex_w = dd + (PAD_W+2)'(1);
                ey_w = ss - (PAD_W+2)'(1);
            end
            default:
            begin
                sx_w = dd - (PAD_W+2)'(1);
                sy_w = ss - (PAD_W+2)'(1);
                ex_w = dd;
                ey_w = ss;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        lp_next    = lp_reg;
        srow_next  = srow_reg;
        scol_next  = scol_reg;
        sside_next = sside_reg;
        fin_next   = fin_reg;
        cmd_ready  = 1'b0;
        mem_we     = 1'b0;
        emit_edge  = 1'b0;
        emit_done  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_LOAD)
                    begin
                        cmd_ready = 1'b1;
                        if (lp_reg < area)
                        begin
                            mem_we  = 1'b1;
                            lp_next = lp_reg + AREA_W'(1);
                        end
                        srow_next  = '0;
                        scol_next  = '0;
                        sside_next = SIDE_UP;
                        fin_next   = 1'b0;
                    end
                    else if (done_now)
                    begin
                        cmd_ready = out_free;
                        if (out_free)
                        begin
                            fin_next  = 1'b1;
                            emit_done = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_ready  = 1'b1;
                        k_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                if (k_reg == WIN_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + WIN_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    if (any_edge)
                    begin
                        emit_edge  = 1'b1;
                        state_next = ST_IDLE;
                        if (pick == SIDE_RIGHT)
                        begin
                            srow_next  = adv_row;
                            scol_next  = adv_col;
                            sside_next = SIDE_UP;
                        end
                        else
                        begin
                            sside_next = pick + 2'd1;
                        end
                    end
                    else
                    begin
                        srow_next  = adv_row;
                        scol_next  = adv_col;
                        sside_next = SIDE_UP;
                        if (adv_row > rp1)
                        begin
                            fin_next   = 1'b1;
                            emit_done  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            k_next     = '0;
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            case (cfg.index)
                REG_ROW_COUNT:
                begin
                    rows_next = clamp_dim(cfg.data, DIM_W'(MAX_ROWS));
                    lp_next   = '0;
                    fin_next  = 1'b1;
                end
                REG_COL_COUNT:
                begin
                    cols_next = clamp_dim(cfg.data, DIM_W'(MAX_COLS));
                    lp_next   = '0;
                    fin_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        ov_next = ov_reg;
        if (ov_reg && result.ready)
        begin
            ov_next = 1'b0;
        end
        if (emit_edge || emit_done)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            rows_reg  <= DIM_W'(64);
            cols_reg  <= DIM_W'(64);
            lp_reg    <= '0;
            srow_reg  <= '0;
            scol_reg  <= '0;
            sside_reg <= SIDE_UP;
            fin_reg   <= 1'b1;
            cap_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            lp_reg    <= lp_next;
            srow_reg  <= srow_next;
            scol_reg  <= scol_next;
            sside_reg <= sside_next;
            fin_reg   <= fin_next;
            cap_reg   <= (state_reg == ST_FETCH);
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[lp_reg[ADDR_W-1:0]] <= cmd.solid;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        rdv_reg <= in_map;
        rk_reg  <= k_reg;
        if (cap_reg)
        begin
            win_reg[rk_reg] <= rdv_reg && rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_edge)
        begin
            out_has_edge_reg <= 1'b1;
            out_done_reg     <= 1'b0;
            out_row_reg      <= srow_reg;
            out_col_reg      <= scol_reg;
            out_side_reg     <= pick;
            out_sx_reg       <= sx_w[XY_W-1:0];
            out_sy_reg       <= sy_w[YY_W-1:0];
            out_ex_reg       <= ex_w[XY_W-1:0];
            out_ey_reg       <= ey_w[YY_W-1:0];
        end
        else if (emit_done)
        begin
            out_has_edge_reg <= 1'b0;
            out_done_reg     <= 1'b1;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            out_side_reg     <= SIDE_UP;
            out_sx_reg       <= '0;
            out_sy_reg       <= '0;
            out_ex_reg       <= '0;
            out_ey_reg       <= '0;
        end
    end

    assign result.valid    = ov_reg;
    assign result.has_edge = out_has_edge_reg;
    assign result.done_res = out_done_reg;
    assign result.cell_row = out_row_reg;
    assign result.cell_col = out_col_reg;
    assign result.side     = out_side_reg;
    assign result.start_x  = out_sx_reg;
    assign result.start_y  = out_sy_reg;
    assign result.end_x    = out_ex_reg;
    assign result.end_y    = out_ey_reg;

    assign stat.finished = fin_reg;
    assign stat.busy     = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// File: hdl/grid_boundary_edge_extractor.sv
// Top level of the grid boundary edge extractor: front stage, command queue, scan engine.
// Depends on gbe_pkg, the channel interfaces, gbe_front, gbe_fifo and gbe_back.
`default_nettype none

// Load a map of up to 64 by 64 tiles in row-major order, one load transaction per
// tile, then send step transactions; each step returns one result: the next edge
// between a border cell of the one-cell padded grid and a non-border neighbor, or
// done. A load is carried out as soon as it reaches the idle scan engine. A step enters
// the engine and then, for each padded cell visited, reads the 13 window tiles of the
// tile mask through its registered read port, drains the read and evaluates the cell; a
// step after done is answered with done straight from the idle state. A holding register
// and a two-entry queue let up to three commands wait ahead of the engine. Configuration
// writes are always ready; a write of either dimension rewinds the load pointer, so a new
// map must be loaded. The tile mask has no reset.
module grid_boundary_edge_extractor (
    input  wire logic clk,
    input  wire logic rst_n,
    gbe_item_if.sink  item,
    gbe_res_if.source result,
    gbe_cfg_if.sink   cfg
);
    import gbe_pkg::*;

    cmd_t     f_cmd;
    logic     f_valid;
    logic     f_ready;
    cmd_t     q_cmd;
    logic     q_valid;
    logic     q_ready;
    bk_stat_t stat;

    gbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (f_cmd),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready)
    );

    gbe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (f_cmd),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_cmd   (q_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    gbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cfg       (cfg),
        .result    (result),
        .stat      (stat)
    );

    a_done_xor_edge: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.has_edge != result.done_res))
        else $error("result is neither a single edge nor done");

    a_edge_y_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.has_edge) |-> ((result.end_y - result.start_y) == 9'sd1))
        else $error("edge endpoints are not one half tile apart in y");

    a_cfg_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready
         && (cfg.index == REG_ROW_COUNT || cfg.index == REG_COL_COUNT))
        |=> stat.finished)
        else $error("dimension write did not end the scan");

endmodule

`default_nettype wire

// File: tb/tb_grid_boundary_edge_extractor.sv
// Self-checking testbench for grid_boundary_edge_extractor: loads random tile maps and
// walks their boundary edges, predicting each result in a scoreboard class.
// Depends on gbe_pkg, gbe_item_if, gbe_res_if, gbe_cfg_if and the block itself.
`default_nettype none

module tb_grid_boundary_edge_extractor;
    import gbe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic                   has_edge;
        logic                   done_res;
        logic [PAD_W-1:0]       cell_row;
        logic [PAD_W-1:0]       cell_col;
        logic [1:0]             side;
        logic signed [XY_W-1:0] start_x;
        logic signed [YY_W-1:0] start_y;
        logic signed [XY_W-1:0] end_x;
        logic signed [YY_W-1:0] end_y;
    } edge_rec_t;

    class edge_scoreboard;
        bit        mask [MEM_DEPTH];
        int        rows;
        int        cols;
        int        load_ptr;
        int        loaded_hi;
        int        scan_r;
        int        scan_c;
        int        scan_s;
        bit        scan_over;
        int        errors;
        int        n_loads;
        int        n_steps;
        int        n_edges;
        int        n_done;
        edge_rec_t pending_edges [$];

        function new();
            rows = MAX_ROWS;
            cols = MAX_COLS;
            load_ptr = 0;
            loaded_hi = 0;
            scan_r = 0;
            scan_c = 0;
            scan_s = 0;
            scan_over = 1'b1;
            errors = 0;
            n_loads = 0;
            n_steps = 0;
            n_edges = 0;
            n_done = 0;
        endfunction

        function int area();
            return rows * cols;
        endfunction

        function bit map_defined();
            return loaded_hi >= area();
        endfunction

        function bit step_safe();
            return scan_over || map_defined();
        endfunction

        function longint step_cost();
            return 15 * (rows + 2) * (cols + 2) + 40;
        endfunction

        function int clamp_dim(int v, int hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void take_config(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            if (idx == REG_ROW_COUNT)
                rows = clamp_dim(int'(val), MAX_ROWS);
            else if (idx == REG_COL_COUNT)
                cols = clamp_dim(int'(val), MAX_COLS);
            else
                return;
            load_ptr = 0;
            scan_over = 1'b1;
        endfunction

        function bit tile(int tr, int tc);
            int idx;
            idx = tr * cols + tc;
            if (idx >= MEM_DEPTH)
                return 1'b0;
            return mask[idx];
        endfunction

        function bit on_border(int r, int c);
            int tr;
            int tc;
            if (r == 0 || c == 0 || r == rows + 1 || c == cols + 1)
                return 1'b1;
            tr = r - 1;
            tc = c - 1;
            if (tile(tr, tc))
                return 1'b0;
            return (tr > 0 && tile(tr - 1, tc)) || (tr + 1 < rows && tile(tr + 1, tc)) ||
                   (tc > 0 && tile(tr, tc - 1)) || (tc + 1 < cols && tile(tr, tc + 1));
        endfunction

        function bit crosses(int r, int c, int s);
            if (!on_border(r, c))
                return 1'b0;
            case (2'(s))
                SIDE_UP:   return r != 0 && !on_border(r - 1, c);
                SIDE_DOWN: return r != rows + 1 && !on_border(r + 1, c);
                SIDE_LEFT: return c != 0 && !on_border(r, c - 1);
                default:   return c != cols + 1 && !on_border(r, c + 1);
            endcase
        endfunction

        function edge_rec_t next_edge();
            edge_rec_t res;
            int        r;
            int        c;
            int        s;
            int        d;
            int        sm;
            int        sx;
            int        sy;
            int        ex;
            int        ey;
            res = '{default: 0};
            while (!scan_over) begin
                if (scan_r > rows + 1 || scan_c > cols + 1) begin
                    scan_over = 1'b1;
                    break;
                end
                r = scan_r;
                c = scan_c;
                s = scan_s;
                scan_s++;
                if (scan_s > 3) begin
                    scan_s = 0;
                    scan_c++;
                    if (scan_c > cols + 1) begin
                        scan_c = 0;
                        scan_r++;
                    end
                end
                if (crosses(r, c, s)) begin
                    d = r - c;
                    sm = r + c;
                    case (2'(s))
                        SIDE_UP:   begin sx = d;     sy = sm - 2; ex = d - 1; ey = sm - 1; end
                        SIDE_DOWN: begin sx = d + 1; sy = sm - 1; ex = d;     ey = sm;     end
                        SIDE_LEFT: begin sx = d;     sy = sm - 2; ex = d + 1; ey = sm - 1; end
                        default:   begin sx = d - 1; sy = sm - 1; ex = d;     ey = sm;     end
                    endcase
                    res.has_edge = 1'b1;
                    res.cell_row = PAD_W'(r);
                    res.cell_col = PAD_W'(c);
                    res.side = 2'(s);
                    res.start_x = XY_W'(sx);
                    res.start_y = YY_W'(sy);
                    res.end_x = XY_W'(ex);
                    res.end_y = YY_W'(ey);
                    return res;
                end
            end
            res.done_res = 1'b1;
            return res;
        endfunction

        function void take_item(logic k, logic s);
            if (k == OP_LOAD) begin
                n_loads++;
                if (load_ptr < area()) begin
                    mask[load_ptr] = s;
                    load_ptr++;
                    if (load_ptr > loaded_hi)
                        loaded_hi = load_ptr;
                end
                scan_r = 0;
                scan_c = 0;
                scan_s = 0;
                scan_over = 1'b0;
            end else begin
                n_steps++;
                pending_edges.insert(pending_edges.size(), next_edge());
            end
        endfunction

        function void match(string name, logic signed [31:0] want, logic signed [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_edge(edge_rec_t got);
            edge_rec_t want;
            if (pending_edges.size() == 0) begin
                $error("result transaction with no expected result pending");
                errors++;
                return;
            end
            want = pending_edges.pop_front();
            if (want.done_res)
                n_done++;
            else
                n_edges++;
            match("has_edge", want.has_edge, got.has_edge);
            match("done_res", want.done_res, got.done_res);
            match("cell_row", want.cell_row, got.cell_row);
            match("cell_col", want.cell_col, got.cell_col);
            match("side", want.side, got.side);
            match("start_x", want.start_x, got.start_x);
            match("start_y", want.start_y, got.start_y);
            match("end_x", want.end_x, got.end_x);
            match("end_y", want.end_y, got.end_y);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gbe_item_if item_bus ();
    gbe_res_if  res_bus ();
    gbe_cfg_if  cfg_bus ();

    grid_boundary_edge_extractor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    edge_scoreboard board;
    longint         budget = 0;
    longint         cycles = 0;
    int             fed = 0;
    int             phases = 0;
    bit             feed_calm = 1'b0;
    bit             sink_calm = 1'b0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic int pick_dim(bit big);
        if (!big)
            return $urandom_range(0, 6);
        if ($urandom_range(0, 2) == 0)
            return MAX_ROWS;
        return $urandom_range(65, 127);
    endfunction

    task automatic send_item(input logic k, input logic s);
        int gap;
        gap = draw_wait(feed_calm);
        if ($urandom_range(0, 49) == 0)
            feed_calm = !feed_calm;
        budget += gap + ((k == OP_STEP) ? board.step_cost() : 40);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.kind <= k;
        item_bus.solid <= s;
        @(negedge clk);
        while (!item_bus.ready)
            @(negedge clk);
        @(posedge clk);
        board.take_item(k, s);
        fed++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        budget += 40;
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        board.take_config(idx, val);
    endtask

    task automatic cfg_done();
        cfg_bus.valid <= 1'b0;
    endtask

    // hold until every pending result is back and queued loads have drained
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (board.pending_edges.size() != 0)
            @(posedge clk);
        budget += 40;
        repeat (32) @(posedge clk);
    endtask

    task automatic step_until_done(input int cap, input int noise_max);
        int n;
        int noise;
        n = 0;
        noise = 0;
        while (!board.scan_over && board.step_safe() && n < cap) begin
            if (noise < noise_max && board.map_defined() && $urandom_range(0, 11) == 0) begin
                send_item(OP_LOAD, 1'($urandom));
                noise++;
            end else begin
                send_item(OP_STEP, 1'($urandom));
            end
            n++;
        end
        if (board.scan_over)
            repeat ($urandom_range(0, 2)) send_item(OP_STEP, 1'($urandom));
    endtask

    task automatic random_phase();
        int mode;
        int rv;
        int cv;
        int cnt;
        int dens;
        mode = $urandom_range(0, 9);
        case (mode)
            0:       begin rv = pick_dim(1'b1); cv = $urandom_range(0, 1); end
            1:       begin rv = $urandom_range(0, 1); cv = pick_dim(1'b1); end
            2:       begin rv = pick_dim(1'b1); cv = pick_dim(1'b1); end
            3:
            begin
                rv = (board.area() <= 64) ? board.rows : pick_dim(1'b0);
                cv = (board.area() <= 64) ? board.cols : pick_dim(1'b0);
            end
            default: begin rv = pick_dim(1'b0); cv = pick_dim(1'b0); end
        endcase
        if ($urandom_range(0, 7) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, DIM_W'($urandom));
        if ($urandom_range(0, 1)) begin
            cfg_write(REG_ROW_COUNT, DIM_W'(rv));
            cfg_write(REG_COL_COUNT, DIM_W'(cv));
        end else begin
            cfg_write(REG_COL_COUNT, DIM_W'(cv));
            cfg_write(REG_ROW_COUNT, DIM_W'(rv));
        end
        cfg_done();
        phases++;
        if ($urandom_range(0, 3) == 0)
            send_item(OP_STEP, 1'($urandom));
        if (mode == 2) begin
            repeat ($urandom_range(0, 6)) send_item(OP_LOAD, 1'($urandom));
        end else begin
            case ($urandom_range(0, 4))
                0:       dens = 0;
                1:       dens = 15;
                2:       dens = 50;
                3:       dens = 85;
                default: dens = 100;
            endcase
            cnt = board.area();
            if (mode == 3 && board.map_defined())
                cnt = $urandom_range(1, cnt);
            repeat (cnt) begin
                if (board.map_defined() && $urandom_range(0, 15) == 0)
                    send_item(OP_STEP, 1'($urandom));
                send_item(OP_LOAD, 1'($urandom_range(0, 99) < dens));
            end
            step_until_done(($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 4000, 2);
        end
        settle();
    endtask

    initial begin
        while (cycles <= 3 * budget + 20000) begin
            @(posedge clk);
            cycles++;
        end
        $error("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
    end

    initial begin
        edge_rec_t got;
        int        stall;
        res_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            stall = draw_wait(sink_calm);
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(negedge clk);
            while (!res_bus.valid)
                @(negedge clk);
            got.has_edge = res_bus.has_edge;
            got.done_res = res_bus.done_res;
            got.cell_row = res_bus.cell_row;
            got.cell_col = res_bus.cell_col;
            got.side = res_bus.side;
            got.start_x = res_bus.start_x;
            got.start_y = res_bus.start_y;
            got.end_x = res_bus.end_x;
            got.end_y = res_bus.end_y;
            @(posedge clk);
            board.check_edge(got);
        end
    end

    initial begin
        int target;
        board = new();
        rst_n <= 1'b0;
        item_bus.valid <= 1'b0;
        item_bus.kind <= OP_LOAD;
        item_bus.solid <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= REG_ROW_COUNT;
        cfg_bus.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no map after reset: done at once
        send_item(OP_STEP, 1'b1);
        settle();
        cfg_write(REG_SPARE_2, 7'h2a);
        cfg_write(REG_SPARE_3, 7'h55);
        cfg_write(REG_ROW_COUNT, 7'd0);
        cfg_write(REG_COL_COUNT, 7'd0);
        cfg_done();
        send_item(OP_STEP, 1'b0);
        send_item(OP_LOAD, 1'b1);
        step_until_done(16, 0);
        // load past the map: rewind only
        send_item(OP_LOAD, 1'b0);
        send_item(OP_STEP, 1'b1);
        settle();
        cfg_write(REG_ROW_COUNT, 7'd2);
        cfg_write(REG_COL_COUNT, 7'd2);
        cfg_done();
        send_item(OP_LOAD, 1'b1);
        send_item(OP_LOAD, 1'b0);
        send_item(OP_LOAD, 1'b0);
        send_item(OP_LOAD, 1'b0);
        step_until_done(32, 0);
        settle();

        target = fed + 750;
        while (fed < target)
            random_phase();

        settle();
        repeat (40) @(posedge clk);
        $display("ran %0d transactions (%0d loads, %0d steps) over %0d map settings",
                 fed, board.n_loads, board.n_steps, phases);
        $display("checked %0d edge results and %0d done results", board.n_edges, board.n_done);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/gbe_pkg.sv
hdl/gbe_item_if.sv
hdl/gbe_res_if.sv
hdl/gbe_cfg_if.sv
hdl/gbe_front.sv
hdl/gbe_fifo.sv
hdl/gbe_back.sv
hdl/grid_boundary_edge_extractor.sv
tb/tb_grid_boundary_edge_extractor.sv
